@@ rtl/ffpa_pkg.sv @@
package ffpa_pkg;

    localparam int PAGE_BYTES  = 4096;
    localparam int GRAIN_BYTES = 8;
    localparam int MAX_CHUNKS  = 512;

    localparam int IDX_W = $clog2(MAX_CHUNKS);
    localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
    localparam int OFS_W = 12;
    localparam int SZ_W  = 13;
    // Wide enough for an end address above the page (start + length).
    localparam int END_W = $clog2(PAGE_BYTES) + 2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd1;
    localparam logic [2:0] ST_NO_SPACE  = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic             opcode;
        logic [SZ_W-1:0]  req_size;
        logic [OFS_W-1:0] free_offset;
    } t_req;

    typedef struct packed {
        logic [OFS_W-1:0] chunk_offset;
        logic [2:0]       status;
    } t_rsp;

endpackage

@@ rtl/first_fit_page_allocator_unit.sv @@
// The time taken grows with the number of entries in the table, as a request
// scans the table and may shift entries; a bad size or a full table is answered
// without a scan.
// One request at a time; busy stays high until the result strobe.
// Reset (synchronous, active low) empties the table at once; entries are not cleared.
// The result is shown for one cycle with o_done; the receiver cannot stall it.
module first_fit_page_allocator_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  ffpa_pkg::t_req        i_req,
    output logic                  o_done,
    output ffpa_pkg::t_rsp        o_rsp
);

    // One-hot sequencer. Scan states read entry r_idx and then compare it;
    // shift states read one entry and write it to its neighbor.
    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SRD    = 8'b0000_0010,
        S_SCMP   = 8'b0000_0100,
        S_MRD    = 8'b0000_1000,
        S_MWR    = 8'b0001_0000,
        S_INS    = 8'b0010_0000,
        S_DONE   = 8'b0100_0000,
        S_TAIL   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // The chunk table, start and length side by side in one memory.
    localparam int ENT_W = ffpa_pkg::OFS_W + ffpa_pkg::SZ_W;
    logic [ENT_W-1:0] r_mem [ffpa_pkg::MAX_CHUNKS];
    logic [ENT_W-1:0] r_rdata;
    logic             rd_en, wr_en;
    logic [ffpa_pkg::IDX_W-1:0] rd_addr, wr_addr;
    logic [ENT_W-1:0] wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    logic [ffpa_pkg::CNT_W-1:0] r_count, n_count;
    logic [ffpa_pkg::CNT_W-1:0] r_idx, n_idx;   // scan position
    logic [ffpa_pkg::CNT_W-1:0] r_mv, n_mv;     // shift position
    logic [ffpa_pkg::END_W-1:0] r_prev, n_prev; // end of the previous chunk
    logic                       r_op, n_op;
    logic [ffpa_pkg::SZ_W-1:0]  r_size, n_size;
    logic [ffpa_pkg::OFS_W-1:0] r_ofs, n_ofs;
    ffpa_pkg::t_rsp             r_rsp, n_rsp;
    logic                       r_done, n_done;

    logic [ffpa_pkg::OFS_W-1:0] e_start;
    logic [ffpa_pkg::SZ_W-1:0]  e_len;
    logic [ffpa_pkg::END_W-1:0] e_start_x, gap, tail;
    logic                       size_bad;

    assign e_start   = r_rdata[ENT_W-1:ffpa_pkg::SZ_W];
    assign e_len     = r_rdata[ffpa_pkg::SZ_W-1:0];
    assign e_start_x = ffpa_pkg::END_W'(e_start);
    // Separate subtractors form the inner gaps and the tail gap.
    assign gap  = e_start_x - r_prev;
    assign tail = ffpa_pkg::END_W'(ffpa_pkg::PAGE_BYTES) - r_prev;
    assign size_bad = (i_req.req_size == '0) ||
        ((i_req.req_size % ffpa_pkg::SZ_W'(ffpa_pkg::GRAIN_BYTES)) != '0);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        n_mv    = r_mv;
        n_prev  = r_prev;
        n_op    = r_op;
        n_size  = r_size;
        n_ofs   = r_ofs;
        n_rsp   = r_rsp;
        n_done  = 1'b0;
        rd_en   = 1'b0;
        wr_en   = 1'b0;
        rd_addr = r_idx[ffpa_pkg::IDX_W-1:0];
        wr_addr = r_mv[ffpa_pkg::IDX_W-1:0];
        wr_data = r_rdata;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op   = i_req.opcode;
                    n_size = i_req.req_size;
                    n_ofs  = i_req.free_offset;
                    n_idx  = '0;
                    n_prev = '0;
                    n_rsp  = '{chunk_offset: '0, status: ffpa_pkg::ST_OK};
                    if (i_req.opcode == ffpa_pkg::OP_ALLOC && size_bad) begin
                        n_rsp.status = ffpa_pkg::ST_BAD_SIZE;
                        n_state = S_DONE;
                    end else if (i_req.opcode == ffpa_pkg::OP_ALLOC &&
                                 r_count >= ffpa_pkg::CNT_W'(ffpa_pkg::MAX_CHUNKS)) begin
                        n_rsp.status = ffpa_pkg::ST_FULL;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SRD;
                    end
                end
            end
            S_SRD: begin
                if (r_idx >= r_count) begin
                    if (r_op == ffpa_pkg::OP_ALLOC) begin
                        n_state = S_TAIL;
                    end else begin
                        n_rsp.status = ffpa_pkg::ST_NOT_FOUND;
                        n_state = S_DONE;
                    end
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_SCMP;
                end
            end
            S_SCMP: begin
                if (r_op == ffpa_pkg::OP_ALLOC) begin
                    if (e_start_x >= r_prev &&
                        gap >= ffpa_pkg::END_W'(r_size)) begin
                        // Open a hole at r_idx by shifting the upper part up.
                        n_mv    = r_count;
                        n_state = S_MRD;
                    end else begin
                        n_prev  = e_start_x + ffpa_pkg::END_W'(e_len);
                        n_idx   = r_idx + 1'b1;
                        n_state = S_SRD;
                    end
                end else begin
                    if (e_start == r_ofs) begin
                        n_mv    = r_idx;
                        n_state = S_MRD;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_SRD;
                    end
                end
            end
            S_TAIL: begin
                if (r_prev > ffpa_pkg::END_W'(ffpa_pkg::PAGE_BYTES) ||
                    tail < ffpa_pkg::END_W'(r_size)) begin
                    n_rsp.status = ffpa_pkg::ST_NO_SPACE;
                    n_state = S_DONE;
                end else begin
                    n_state = S_INS;
                end
            end
            S_MRD: begin
                // Alloc moves entry mv-1 to mv downward to the hole; free moves
                // entry mv+1 to mv upward to the end.
                if (r_op == ffpa_pkg::OP_ALLOC) begin
                    if (r_mv == r_idx) begin
                        n_state = S_INS;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = ffpa_pkg::IDX_W'(r_mv - 1'b1);
                        n_state = S_MWR;
                    end
                end else begin
                    if (r_mv + 1'b1 >= r_count) begin
                        n_count = r_count - 1'b1;
                        n_state = S_DONE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = ffpa_pkg::IDX_W'(r_mv + 1'b1);
                        n_state = S_MWR;
                    end
                end
            end
            S_MWR: begin
                wr_en = 1'b1;
                if (r_op == ffpa_pkg::OP_ALLOC) begin
                    n_mv = r_mv - 1'b1;
                end else begin
                    n_mv = r_mv + 1'b1;
                end
                n_state = S_MRD;
            end
            S_INS: begin
                wr_en   = 1'b1;
                wr_addr = r_idx[ffpa_pkg::IDX_W-1:0];
                wr_data = {r_prev[ffpa_pkg::OFS_W-1:0], r_size};
                n_count = r_count + 1'b1;
                n_rsp.chunk_offset = r_prev[ffpa_pkg::OFS_W-1:0];
                n_state = S_DONE;
            end
            S_DONE: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
        r_idx  <= n_idx;
        r_mv   <= n_mv;
        r_prev <= n_prev;
        r_op   <= n_op;
        r_size <= n_size;
        r_ofs  <= n_ofs;
        r_rsp  <= n_rsp;
    end

    // The result transfer happens in the cycle after S_DONE, while idle.
    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

@@ rtl/ffpa_checker.sv @@
module ffpa_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_done,
    input ffpa_pkg::t_rsp o_rsp
);

    a_done_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while busy");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rsp.status <= ffpa_pkg::ST_NOT_FOUND))
        else $error("status code out of range");

    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status != ffpa_pkg::ST_OK) |-> (o_rsp.chunk_offset == '0))
        else $error("failing request returned an offset");

endmodule

bind first_fit_page_allocator_unit ffpa_checker u_ffpa_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);

@@ verif/first_fit_page_allocator_unit_tb.sv @@
module first_fit_page_allocator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Clock, reset, handshake and the two payload buses of the unit under test.
    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    ffpa_pkg::t_req i_req;
    logic           o_done;
    ffpa_pkg::t_rsp o_rsp;

    first_fit_page_allocator_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // The predictor keeps its own copy of the chunk table, sorted by start offset.
    logic [ffpa_pkg::OFS_W-1:0] mirror_start[ffpa_pkg::MAX_CHUNKS];
    logic [ffpa_pkg::SZ_W-1:0]  mirror_length[ffpa_pkg::MAX_CHUNKS];
    int                         mirror_count;

    // Expected responses waiting for their strobe, oldest first.
    ffpa_pkg::t_rsp   pending_rsp[$];

    int               error_count;
    int               mismatch_count;
    int               transfer_count;
    int               rsp_count;
    int               idle_cycles;
    int               alloc_ok_count;
    int               free_ok_count;
    int               status_seen[5];
    bit               timed_out;

    localparam int WATCHDOG_LIMIT = 20000;

    // Work out the response to one request and update the mirror table.
    function automatic ffpa_pkg::t_rsp predict_allocation(ffpa_pkg::t_req req);
        ffpa_pkg::t_rsp rsp;
        int unsigned    prev_end;
        int unsigned    pos;
        int unsigned    size;
        bit             found;
        rsp      = '0;
        prev_end = 0;
        found    = 1'b0;
        size     = req.req_size;
        if (req.opcode == ffpa_pkg::OP_ALLOC) begin
            if (size == 0 || (size % ffpa_pkg::GRAIN_BYTES) != 0) begin
                rsp.status = ffpa_pkg::ST_BAD_SIZE;
                return rsp;
            end
            if (mirror_count >= ffpa_pkg::MAX_CHUNKS) begin
                rsp.status = ffpa_pkg::ST_FULL;
                return rsp;
            end
            for (pos = 0; pos < mirror_count; pos++) begin
                if (mirror_start[pos] >= prev_end &&
                    mirror_start[pos] - prev_end >= size) begin
                    found = 1'b1;
                    break;
                end
                prev_end = mirror_start[pos] + mirror_length[pos];
            end
            if (!found && (prev_end > ffpa_pkg::PAGE_BYTES ||
                           ffpa_pkg::PAGE_BYTES - prev_end < size)) begin
                rsp.status = ffpa_pkg::ST_NO_SPACE;
                return rsp;
            end
            for (int j = mirror_count; j > pos; j--) begin
                mirror_start[j]  = mirror_start[j-1];
                mirror_length[j] = mirror_length[j-1];
            end
            mirror_start[pos]  = prev_end[ffpa_pkg::OFS_W-1:0];
            mirror_length[pos] = size[ffpa_pkg::SZ_W-1:0];
            mirror_count++;
            rsp.chunk_offset = prev_end[ffpa_pkg::OFS_W-1:0];
            rsp.status       = ffpa_pkg::ST_OK;
            return rsp;
        end
        for (int i = 0; i < mirror_count; i++) begin
            if (mirror_start[i] == req.free_offset) begin
                for (int j = i; j + 1 < mirror_count; j++) begin
                    mirror_start[j]  = mirror_start[j+1];
                    mirror_length[j] = mirror_length[j+1];
                end
                mirror_count--;
                rsp.status = ffpa_pkg::ST_OK;
                return rsp;
            end
        end
        rsp.status = ffpa_pkg::ST_NOT_FOUND;
        return rsp;
    endfunction

    // Picks the start of a live chunk, or a random grain offset when the table is empty, so that most frees hit.
    function automatic logic [ffpa_pkg::OFS_W-1:0] pick_live_offset();
        if (mirror_count == 0) begin
            return ffpa_pkg::OFS_W'($urandom_range(0, 511) * ffpa_pkg::GRAIN_BYTES);
        end
        return mirror_start[$urandom_range(0, mirror_count - 1)];
    endfunction

    // Response checker: every strobe must match the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_rsp.size() == 0) begin
                if (mismatch_count < 10) begin
                    $display("ERROR: unexpected response offset=%0d status=%0d",
                             o_rsp.chunk_offset, o_rsp.status);
                end
                error_count++;
                mismatch_count++;
            end else begin
                if (o_rsp.chunk_offset !== pending_rsp[0].chunk_offset ||
                    o_rsp.status !== pending_rsp[0].status) begin
                    if (mismatch_count < 10) begin
                        $display("ERROR: response %0d expected offset=%0d status=%0d,",
                                 rsp_count, pending_rsp[0].chunk_offset,
                                 pending_rsp[0].status);
                        $display("       got offset=%0d status=%0d",
                                 o_rsp.chunk_offset, o_rsp.status);
                    end
                    error_count++;
                    mismatch_count++;
                end
                void'(pending_rsp.pop_front());
            end
            rsp_count++;
        end
    end

    // Watchdog: counts cycles in which neither a request nor a response is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("ERROR: watchdog expired with %0d responses pending",
                     pending_rsp.size());
            $display("first_fit_page_allocator_unit test failed");
            $finish;
        end
    end

    // One request transfer. The request is driven at the falling edge and held
    // until the rising edge at which busy is low; the expectation is queued then.
    task automatic send_request(ffpa_pkg::t_req req, bit has_typed,
                                ffpa_pkg::t_rsp typed_rsp);
        ffpa_pkg::t_rsp predicted;
        start <= 1'b1;
        i_req <= req;
        do begin
            @(posedge i_clk);
        end while (busy);
        predicted = predict_allocation(req);
        if (has_typed && predicted !== typed_rsp) begin
            error_count++;
            $display("ERROR: directed row %0d predictor gives offset=%0d status=%0d,",
                     transfer_count, predicted.chunk_offset, predicted.status);
            $display("       table says %0d/%0d",
                     typed_rsp.chunk_offset, typed_rsp.status);
        end
        pending_rsp.push_back(has_typed ? typed_rsp : predicted);
        if (predicted.status <= ffpa_pkg::ST_NOT_FOUND) begin
            status_seen[predicted.status]++;
        end
        if (predicted.status == ffpa_pkg::ST_OK) begin
            if (req.opcode == ffpa_pkg::OP_ALLOC) alloc_ok_count++;
            else free_ok_count++;
        end
        transfer_count++;
        @(negedge i_clk);
    endtask

    // Lowers start for a random burst of cycles.
    task automatic idle_burst();
        start <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge i_clk);
    endtask

    // Directed table: opcode, size, offset, whether the response is typed in,
    // and the typed response.
    typedef struct {
        logic                       opcode;
        logic [ffpa_pkg::SZ_W-1:0]  req_size;
        logic [ffpa_pkg::OFS_W-1:0] free_offset;
        bit                         has_typed;
        logic [ffpa_pkg::OFS_W-1:0] rsp_offset;
        logic [2:0]                 rsp_status;
    } t_directed_row;

    t_directed_row directed_rows[] = '{
        // An empty table after reset: a free finds nothing.
        '{ffpa_pkg::OP_FREE,  13'd0,    12'd0,   1'b1, 12'd0,  ffpa_pkg::ST_NOT_FOUND},
        // Bad sizes: zero, off-grain, and all bits of the size field set.
        '{ffpa_pkg::OP_ALLOC, 13'd0,    12'd0,   1'b1, 12'd0,  ffpa_pkg::ST_BAD_SIZE},
        '{ffpa_pkg::OP_ALLOC, 13'd7,    12'd0,   1'b1, 12'd0,  ffpa_pkg::ST_BAD_SIZE},
        '{ffpa_pkg::OP_ALLOC, 13'h1FFF, 12'hFFF, 1'b1, 12'd0,  ffpa_pkg::ST_BAD_SIZE},
        // Larger than the page but on the grain.
        '{ffpa_pkg::OP_ALLOC, 13'h1FF8, 12'd0,   1'b1, 12'd0,  ffpa_pkg::ST_NO_SPACE},
        '{ffpa_pkg::OP_ALLOC, 13'd4104, 12'd0,   1'b1, 12'd0,  ffpa_pkg::ST_NO_SPACE},
        // The whole page, then nothing fits.
        '{ffpa_pkg::OP_ALLOC, 13'd4096, 12'hFFF, 1'b1, 12'd0,  ffpa_pkg::ST_OK},
        '{ffpa_pkg::OP_ALLOC, 13'd8,    12'd0,   1'b1, 12'd0,  ffpa_pkg::ST_NO_SPACE},
        '{ffpa_pkg::OP_FREE,  13'h1FFF, 12'd8,   1'b1, 12'd0,  ffpa_pkg::ST_NOT_FOUND},
        '{ffpa_pkg::OP_FREE,  13'd0,    12'd0,   1'b1, 12'd0,  ffpa_pkg::ST_OK},
        // Build a few chunks and punch holes in the middle.
        '{ffpa_pkg::OP_ALLOC, 13'd8,    12'd0,   1'b1, 12'd0,  ffpa_pkg::ST_OK},
        '{ffpa_pkg::OP_ALLOC, 13'd16,   12'd0,   1'b1, 12'd8,  ffpa_pkg::ST_OK},
        '{ffpa_pkg::OP_ALLOC, 13'd24,   12'd0,   1'b1, 12'd24, ffpa_pkg::ST_OK},
        '{ffpa_pkg::OP_FREE,  13'd0,    12'd8,   1'b0, 12'd0,  ffpa_pkg::ST_OK},
        '{ffpa_pkg::OP_ALLOC, 13'd8,    12'd0,   1'b0, 12'd0,  ffpa_pkg::ST_OK},
        '{ffpa_pkg::OP_ALLOC, 13'd16,   12'd0,   1'b0, 12'd0,  ffpa_pkg::ST_OK},
        '{ffpa_pkg::OP_FREE,  13'd0,    12'd0,   1'b0, 12'd0,  ffpa_pkg::ST_OK},
        // A tail request just too large for what is left.
        '{ffpa_pkg::OP_ALLOC, 13'd4040, 12'd0,   1'b0, 12'd0,  ffpa_pkg::ST_OK},
        '{ffpa_pkg::OP_FREE,  13'd0,    12'hFF8, 1'b0, 12'd0,  ffpa_pkg::ST_OK},
        '{ffpa_pkg::OP_FREE,  13'd0,    12'hFFF, 1'b1, 12'd0,  ffpa_pkg::ST_NOT_FOUND},
        '{ffpa_pkg::OP_FREE,  13'd0,    12'd4,   1'b1, 12'd0,  ffpa_pkg::ST_NOT_FOUND}
    };

    initial begin
        ffpa_pkg::t_req req;
        ffpa_pkg::t_rsp typed;
        int             deadline;
        error_count    = 0;
        mismatch_count = 0;
        transfer_count = 0;
        rsp_count      = 0;
        idle_cycles    = 0;
        alloc_ok_count = 0;
        free_ok_count  = 0;
        timed_out      = 1'b0;
        mirror_count   = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
        start   = 1'b0;
        i_req   = '0;
        typed   = '0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed rows, back to back.
        foreach (directed_rows[r]) begin
            req.opcode       = directed_rows[r].opcode;
            req.req_size     = directed_rows[r].req_size;
            req.free_offset  = directed_rows[r].free_offset;
            typed.chunk_offset = directed_rows[r].rsp_offset;
            typed.status       = directed_rows[r].rsp_status;
            send_request(req, directed_rows[r].has_typed, typed);
        end

        // Empty the table, fill it to its limit with single grains, then hit
        // table full, and then a bad size, which wins. Only this reaches the full case.
        while (mirror_count > 0) begin
            req = '{ffpa_pkg::OP_FREE, '0, mirror_start[0]};
            send_request(req, 1'b0, typed);
        end
        for (int n = 0; n < ffpa_pkg::MAX_CHUNKS; n++) begin
            req = '{ffpa_pkg::OP_ALLOC, ffpa_pkg::SZ_W'(ffpa_pkg::GRAIN_BYTES),
                    ffpa_pkg::OFS_W'($urandom)};
            send_request(req, 1'b0, typed);
        end
        req = '{ffpa_pkg::OP_ALLOC, ffpa_pkg::SZ_W'(ffpa_pkg::GRAIN_BYTES), '0};
        send_request(req, 1'b0, typed);
        req = '{ffpa_pkg::OP_ALLOC, 13'h1FFF, '0};
        send_request(req, 1'b0, typed);

        // Random part. Mostly well-formed: grain-sized allocations and frees of
        // live chunks; some noise sizes and stray offsets. Idling stops near the end.
        for (int n = 0; n < 24; n++) begin
            int unsigned pick;
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                req.opcode      = ffpa_pkg::OP_ALLOC;
                req.req_size    = ($urandom_range(0, 9) == 0)
                    ? ffpa_pkg::SZ_W'($urandom_range(1, 512) * ffpa_pkg::GRAIN_BYTES)
                    : ffpa_pkg::SZ_W'($urandom_range(1, 24) * ffpa_pkg::GRAIN_BYTES);
                req.free_offset = ffpa_pkg::OFS_W'($urandom);
            end else if (pick < 88) begin
                req.opcode      = ffpa_pkg::OP_FREE;
                req.req_size    = ffpa_pkg::SZ_W'($urandom);
                req.free_offset = pick_live_offset();
            end else begin
                req.opcode      = ffpa_pkg::OP_ALLOC + pick[0];
                req.req_size    = ffpa_pkg::SZ_W'($urandom);
                req.free_offset = ffpa_pkg::OFS_W'($urandom);
            end
            send_request(req, 1'b0, typed);
            if (n < 16 && $urandom_range(0, 3) == 0) begin
                idle_burst();
            end
        end
        start <= 1'b0;

        // Drain, then wait out the longest latency for stray strobes.
        deadline = 0;
        while (pending_rsp.size() != 0 && deadline < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            deadline++;
        end
        repeat (2 * ffpa_pkg::MAX_CHUNKS + 16) @(posedge i_clk);

        $display("Covered %0d requests: %0d allocations and %0d frees succeeded,",
                 transfer_count, alloc_ok_count, free_ok_count);
        $display("with %0d bad size, %0d no space, %0d table full and %0d unknown offset.",
                 status_seen[ffpa_pkg::ST_BAD_SIZE], status_seen[ffpa_pkg::ST_NO_SPACE],
                 status_seen[ffpa_pkg::ST_FULL], status_seen[ffpa_pkg::ST_NOT_FOUND]);
        if (error_count == 0 && pending_rsp.size() == 0) begin
            $display("first_fit_page_allocator_unit test passed");
        end else begin
            $display("first_fit_page_allocator_unit test failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/ffpa_pkg.sv
rtl/first_fit_page_allocator_unit.sv
rtl/ffpa_checker.sv
verif/first_fit_page_allocator_unit_tb.sv
